FILE: hdl/scfp_pkg.sv
// Shared types and constants for the serial command frame parser.
// No dependencies; scfp_cell and the core in hdl/ refer to this package by scoped names.
`default_nettype none

package scfp_pkg;

    localparam int STORE_DEPTH         = 15;
    localparam int IDX_W               = 4;
    localparam int MAX_FRAME_BYTES_DEF = 20;

    localparam logic [7:0] HEAD_FIRST  = 8'hFF;
    localparam logic [7:0] HEAD_SECOND = 8'hAA;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_CHECK = 2'd1,
        ST_SIZE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR2,
        S_SIZE,
        S_CMD,
        S_BODY,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] command_code;
        t_idx       payload_length;
        t_idx       byte_index;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } t_result;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hdl/scfp_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Payload types come from scfp_pkg.
`default_nettype none

interface scfp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/scfp_cell.sv
// One payload cell of the store chain: loads a received byte or takes its neighbor's byte.
// Depends on scfp_pkg for the control struct.
`default_nettype none

module scfp_cell (
    input  wire                  i_clk,
    input  wire scfp_pkg::t_cell_ctl i_ctl,
    input  wire  [7:0]           i_load_data,
    input  wire  [7:0]           i_shift_data,
    output logic [7:0]           o_data
);
    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_shift_data;
        end else if (i_ctl.load) begin
            n_data = i_load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

`default_nettype wire

FILE: hdl/serial_command_frame_parser_core.sv
// Top level of the serial command frame parser: header sequencer, cell chain, result register.
// Depends on scfp_pkg, scfp_stream_if and scfp_cell.
`default_nettype none

//  channel  | modport | payload                                    | transaction
//  ---------+---------+--------------------------------------------+--------------------------
//  i_rx     | sink    | rx_byte                                    | one received byte
//  o_res    | source  | status, command_code, payload_length,      | one result item
//           |         | byte_index, payload_byte, byte_valid, last |
//
// The check byte of a good frame with N payload bytes starts a drain of the N bytes
// through the cell chain, one result per cycle while o_res keeps up; i_rx.ready stays
// low for the drain. Reset is synchronous and clears the sequencer and the result
// valid; the cells carry no reset. A stall on o_res holds the result register and the
// drain.

module serial_command_frame_parser_core #(
    parameter int MAX_FRAME_BYTES = scfp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    scfp_stream_if.sink    i_rx,
    scfp_stream_if.source  o_res
);
    localparam int DEPTH = scfp_pkg::STORE_DEPTH;

    // Sequencer state
    scfp_pkg::t_state  r_state, n_state;
    logic [7:0]        r_size, n_size;
    logic [7:0]        r_cmd, n_cmd;
    scfp_pkg::t_idx    r_k, n_k;       // payload bytes stored so far
    scfp_pkg::t_idx    r_idx, n_idx;   // next result index during the drain

    // Result register
    logic              r_out_valid, n_out_valid;
    scfp_pkg::t_result r_res, n_res;

    logic              slot_free;
    logic              in_take;
    logic              load_en;
    logic              shift_en;
    logic [7:0]        rx_b;
    logic [4:0]        plen;
    logic              too_large;
    logic              check_ok;

    scfp_pkg::t_cell_ctl cell_ctl [DEPTH];
    logic [7:0]          cell_q   [DEPTH];

    assign rx_b      = i_rx.payload.rx_byte;
    assign slot_free = !r_out_valid || o_res.ready;
    assign i_rx.ready = (r_state != scfp_pkg::S_DRAIN) && slot_free;
    assign in_take   = i_rx.valid && i_rx.ready;

    // Payload bytes before the check byte; only meaningful once size is checked.
    assign plen      = 5'(r_size - 8'd1);
    assign too_large = ((9'(r_size) + 9'd4) > 9'(MAX_FRAME_BYTES))
                    || (r_size > 8'(DEPTH + 1));
    assign check_ok  = ({1'b0, rx_b} == ({1'b0, r_cmd} + 9'd1));

    // Cell chain: cell i loads while it is the write slot; all cells step toward
    // cell 0 during the drain, and cell 0 feeds the result register.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [7:0] shift_in;

        if (i == DEPTH - 1) begin : g_tail
            assign shift_in = 8'd0;
        end else begin : g_body
            assign shift_in = cell_q[i+1];
        end

        assign cell_ctl[i].load  = load_en && (r_k == scfp_pkg::t_idx'(i));
        assign cell_ctl[i].shift = shift_en;

        scfp_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[i]),
            .i_load_data  (rx_b),
            .i_shift_data (shift_in),
            .o_data       (cell_q[i])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_cmd       = r_cmd;
        n_k         = r_k;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_res       = r_res;
        load_en     = 1'b0;
        shift_en    = 1'b0;

        case (r_state)
            scfp_pkg::S_IDLE: begin
                if (in_take && rx_b == scfp_pkg::HEAD_FIRST) begin
                    n_state = scfp_pkg::S_HDR2;
                end
            end
            scfp_pkg::S_HDR2: begin
                // A wrong second byte drops the frame and is not a new start.
                if (in_take) begin
                    n_state = (rx_b == scfp_pkg::HEAD_SECOND) ? scfp_pkg::S_SIZE
                                                              : scfp_pkg::S_IDLE;
                end
            end
            scfp_pkg::S_SIZE: begin
                if (in_take) begin
                    n_size  = rx_b;
                    n_state = scfp_pkg::S_CMD;
                end
            end
            scfp_pkg::S_CMD: begin
                if (in_take) begin
                    n_k = '0;
                    if (r_size == 8'd0 || too_large) begin
                        // Size zero means the command is the check byte: always a mismatch.
                        n_out_valid = 1'b1;
                        n_res       = '0;
                        n_res.status       = (r_size == 8'd0) ? scfp_pkg::ST_CHECK
                                                              : scfp_pkg::ST_SIZE;
                        n_res.command_code = rx_b;
                        n_res.last         = 1'b1;
                        n_state = scfp_pkg::S_IDLE;
                        n_size  = '0;
                        n_cmd   = '0;
                    end else begin
                        n_cmd   = rx_b;
                        n_state = scfp_pkg::S_BODY;
                    end
                end
            end
            scfp_pkg::S_BODY: begin
                if (in_take) begin
                    if ({1'b0, r_k} >= plen) begin
                        n_out_valid = 1'b1;
                        n_res       = '0;
                        n_res.command_code = r_cmd;
                        if (!check_ok) begin
                            n_res.status = scfp_pkg::ST_CHECK;
                            n_res.last   = 1'b1;
                            n_state = scfp_pkg::S_IDLE;
                            n_size  = '0;
                            n_cmd   = '0;
                        end else if (plen == 5'd0) begin
                            // Empty good frame: one result with no byte.
                            n_res.status = scfp_pkg::ST_DATA;
                            n_res.last   = 1'b1;
                            n_state = scfp_pkg::S_IDLE;
                            n_size  = '0;
                            n_cmd   = '0;
                        end else begin
                            // Good frame with payload: hand over to the drain.
                            n_out_valid = r_out_valid && !o_res.ready;
                            n_res       = r_res;
                            n_idx       = '0;
                            n_state     = scfp_pkg::S_DRAIN;
                        end
                    end else begin
                        load_en = 1'b1;
                        n_k     = r_k + scfp_pkg::t_idx'(1);
                    end
                end
            end
            scfp_pkg::S_DRAIN: begin
                if (slot_free) begin
                    shift_en    = 1'b1;
                    n_out_valid = 1'b1;
                    n_res.status         = scfp_pkg::ST_DATA;
                    n_res.command_code   = r_cmd;
                    n_res.payload_length = plen[scfp_pkg::IDX_W-1:0];
                    n_res.byte_index     = r_idx;
                    n_res.payload_byte   = cell_q[0];
                    n_res.byte_valid     = 1'b1;
                    n_res.last           = ({1'b0, r_idx} == (plen - 5'd1));
                    if ({1'b0, r_idx} == (plen - 5'd1)) begin
                        n_state = scfp_pkg::S_IDLE;
                        n_size  = '0;
                        n_cmd   = '0;
                    end else begin
                        n_idx = r_idx + scfp_pkg::t_idx'(1);
                    end
                end
            end
            default: begin
                n_state = scfp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scfp_pkg::S_IDLE;
            r_size      <= '0;
            r_cmd       <= '0;
            r_k         <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_cmd       <= n_cmd;
            r_k         <= n_k;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result payload without reset; valid qualifies it.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;
endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for serial_command_frame_parser_core.
// Depends on scfp_pkg and scfp_stream_if; drives bytes, predicts results, compares each one.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int FRAME_LIMIT    = scfp_pkg::MAX_FRAME_BYTES_DEF;
    localparam int RANDOM_BYTES   = 325;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    scfp_stream_if #(.t_payload(scfp_pkg::t_rx_item)) rx_if ();
    scfp_stream_if #(.t_payload(scfp_pkg::t_result))  res_if ();

    serial_command_frame_parser_core #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Bytes waiting to be sent and results the parser still owes.
    logic [7:0]        rx_bytes[$];
    scfp_pkg::t_result frame_results_due[$];

    // Predictor state: position in frame, size byte, command byte, stored payload.
    int unsigned frame_pos      = 0;
    logic [7:0]  frame_len_byte = '0;
    logic [7:0]  frame_cmd      = '0;
    logic [7:0]  body_bytes[scfp_pkg::STORE_DEPTH];

    int  fail_count  = 0;
    int  idle_cycles = 0;
    bit  rx_taken    = 1'b0;

    function automatic scfp_pkg::t_result make_result(input scfp_pkg::t_status st,
                                            input logic [7:0] cmd,
                                            input logic [3:0] len, input logic [3:0] idx,
                                            input logic [7:0] val, input logic valid,
                                            input logic last);
        scfp_pkg::t_result r;
        r.status         = st;
        r.command_code   = cmd;
        r.payload_length = len;
        r.byte_index     = idx;
        r.payload_byte   = val;
        r.byte_valid     = valid;
        r.last           = last;
        return r;
    endfunction

    task automatic drop_frame();
        frame_pos      = 0;
        frame_len_byte = '0;
        frame_cmd      = '0;
    endtask

    // Advance the frame parser by one byte and queue whatever results it owes.
    task automatic predict_frame_results(input logic [7:0] b);
        int unsigned k;
        int unsigned plen;
        case (frame_pos)
            0: if (b == scfp_pkg::HEAD_FIRST) frame_pos = 1;
            1: begin
                if (b == scfp_pkg::HEAD_SECOND) frame_pos = 2;
                else drop_frame();
            end
            2: begin
                frame_len_byte = b;
                frame_pos      = 3;
            end
            3: begin
                frame_cmd = b;
                if (frame_len_byte == 0) begin
                    // the command byte doubles as the check byte and can never match
                    frame_results_due.push_back(make_result(scfp_pkg::ST_CHECK, b, '0, '0,
                                                            '0, 1'b0, 1'b1));
                    drop_frame();
                end else if (frame_len_byte + 4 > FRAME_LIMIT ||
                             frame_len_byte > scfp_pkg::STORE_DEPTH + 1) begin
                    frame_results_due.push_back(make_result(scfp_pkg::ST_SIZE, b, '0, '0,
                                                            '0, 1'b0, 1'b1));
                    drop_frame();
                end else begin
                    frame_pos = 4;
                end
            end
            default: begin
                k    = frame_pos - 4;
                plen = frame_len_byte - 1;
                if (k >= plen) begin
                    // check byte: compare at 9 bits so command 0xFF always fails
                    if ({1'b0, b} != {1'b0, frame_cmd} + 9'd1) begin
                        frame_results_due.push_back(
                            make_result(scfp_pkg::ST_CHECK, frame_cmd, '0, '0, '0,
                                        1'b0, 1'b1));
                    end else if (plen == 0) begin
                        frame_results_due.push_back(
                            make_result(scfp_pkg::ST_DATA, frame_cmd, '0, '0, '0,
                                        1'b0, 1'b1));
                    end else begin
                        for (int i = 0; i < plen; i++)
                            frame_results_due.push_back(
                                make_result(scfp_pkg::ST_DATA, frame_cmd, 4'(plen), 4'(i),
                                            body_bytes[i], 1'b1, i + 1 == plen));
                    end
                    drop_frame();
                end else begin
                    body_bytes[k] = b;
                    frame_pos     = frame_pos + 1;
                end
            end
        endcase
    endtask

    // Queue one frame with random payload; oversize and zero-size frames end at the command.
    task automatic queue_frame(input logic [7:0] size_b, input logic [7:0] cmd,
                               input bit bad_check);
        logic [7:0] chk;
        rx_bytes.push_back(scfp_pkg::HEAD_FIRST);
        rx_bytes.push_back(scfp_pkg::HEAD_SECOND);
        rx_bytes.push_back(size_b);
        rx_bytes.push_back(cmd);
        if (size_b != 0 && size_b + 4 <= FRAME_LIMIT &&
            size_b <= scfp_pkg::STORE_DEPTH + 1) begin
            repeat (size_b - 1) rx_bytes.push_back(8'($urandom));
            chk = cmd + 8'd1;
            if (bad_check) chk = chk ^ 8'($urandom_range(1, 255));
            rx_bytes.push_back(chk);
        end
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field,
                     want, got);
    endtask

    // Sample both channels on the rising edge: check results first, then predict.
    always @(posedge i_clk) begin
        scfp_pkg::t_result got;
        scfp_pkg::t_result want;
        rx_taken <= i_rst_n && rx_if.valid === 1'b1 && rx_if.ready === 1'b1;
        if (i_rst_n) begin
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = res_if.payload;
                if (frame_results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result transaction: %p", $realtime, got);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.command_code !== want.command_code)
                        note_mismatch("command_code", 32'(want.command_code),
                                      32'(got.command_code));
                    if (got.payload_length !== want.payload_length)
                        note_mismatch("payload_length", 32'(want.payload_length),
                                      32'(got.payload_length));
                    if (got.byte_index !== want.byte_index)
                        note_mismatch("byte_index", 32'(want.byte_index),
                                      32'(got.byte_index));
                    if (got.payload_byte !== want.payload_byte)
                        note_mismatch("payload_byte", 32'(want.payload_byte),
                                      32'(got.payload_byte));
                    if (got.byte_valid !== want.byte_valid)
                        note_mismatch("byte_valid", 32'(want.byte_valid),
                                      32'(got.byte_valid));
                    if (got.last !== want.last)
                        note_mismatch("last", 32'(want.last), 32'(got.last));
                end
            end
            if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1)
                predict_frame_results(rx_if.payload.rx_byte);

            // watchdog: any transaction on either side resets the count
            if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog expired after %0d idle cycles", idle_cycles);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Byte driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_taken) begin
            if (gap_left > 0 || rx_bytes.size() == 0) begin
                if (gap_left > 0) gap_left = gap_left - 1;
                rx_if.valid <= 1'b0;
            end else begin
                rx_if.payload.rx_byte <= rx_bytes.pop_front();
                rx_if.valid           <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // Result receiver: stall following a random 32-bit pattern, redrawn each time it wraps.
    logic [31:0] rdy_pattern = '1;
    logic [4:0]  rdy_phase   = '0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (rdy_phase == 0) begin
                case ($urandom_range(0, 3))
                    0:       rdy_pattern = '1;
                    1:       rdy_pattern = $urandom;
                    2:       rdy_pattern = $urandom | $urandom;
                    default: rdy_pattern = $urandom & $urandom;
                endcase
            end
            res_if.ready <= rdy_pattern[rdy_phase];
            rdy_phase = rdy_phase + 1;
        end
    end

    initial begin
        int n0;
        int random_bytes;
        int sel;
        logic [7:0] bad_hdr;

        rx_if.valid   = 1'b0;
        rx_if.payload = '0;
        res_if.ready  = 1'b0;

        // Directed frames: noise, broken header, size zero, oversize, empty frames,
        // command 0xFF, and a payload holding both byte extremes.
        rx_bytes.push_back(8'h55);
        rx_bytes.push_back(scfp_pkg::HEAD_FIRST);
        rx_bytes.push_back(scfp_pkg::HEAD_FIRST);   // second header byte wrong: drop the frame
        rx_bytes.push_back(scfp_pkg::HEAD_SECOND);  // not taken as a new header start
        queue_frame(8'd0, 8'h42, 1'b0);
        queue_frame(8'd17, 8'h00, 1'b0);
        queue_frame(8'd1, 8'h00, 1'b0);
        queue_frame(8'd1, 8'hFF, 1'b0);
        rx_bytes.push_back(scfp_pkg::HEAD_FIRST);
        rx_bytes.push_back(scfp_pkg::HEAD_SECOND);
        rx_bytes.push_back(8'd3);
        rx_bytes.push_back(8'hFE);
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(8'hFF);
        rx_bytes.push_back(8'hFF);

        // Random part: mostly well-formed frames, the rest broken frames and noise.
        queue_frame(8'd16, 8'($urandom_range(0, 254)), 1'b0);
        queue_frame(8'hFF, 8'($urandom), 1'b0);
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            n0  = rx_bytes.size();
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                queue_frame(($urandom_range(0, 9) == 0) ? 8'($urandom_range(10, 16))
                                                        : 8'($urandom_range(1, 5)),
                            8'($urandom_range(0, 254)), 1'b0);
            end else if (sel < 78) begin
                queue_frame(8'($urandom_range(1, 16)), 8'($urandom), 1'b1);
            end else if (sel < 82) begin
                queue_frame(8'd0, 8'($urandom), 1'b0);
            end else if (sel < 88) begin
                queue_frame(8'($urandom_range(FRAME_LIMIT - 3, 255)), 8'($urandom), 1'b0);
            end else if (sel < 93) begin
                bad_hdr = 8'($urandom);
                if (bad_hdr == scfp_pkg::HEAD_SECOND) bad_hdr = 8'h55;
                rx_bytes.push_back(scfp_pkg::HEAD_FIRST);
                rx_bytes.push_back(bad_hdr);
            end else begin
                // idle noise is ignored by the parser
                repeat ($urandom_range(1, 3)) rx_bytes.push_back(8'($urandom_range(0, 254)));
            end
            random_bytes += rx_bytes.size() - n0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to be taken and every result to arrive, then let
        // the block settle so any stray result is caught.
        while (rx_bytes.size() != 0 || rx_if.valid === 1'b1) @(posedge i_clk);
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
